FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

FILE: hdl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// types and constants for the lcd scanline timing and status block
// ----------------------------------------------------------------------------
package lst_pkg;

   // dot widths of the fixed phases of a visible line
   localparam int unsigned OAM_DOTS  = 80;
   localparam int unsigned XFER_DOTS = 172;

   // bit positions in the stat enable field
   localparam int unsigned EN_HBLANK = 0;
   localparam int unsigned EN_VBLANK = 1;
   localparam int unsigned EN_OAM    = 2;
   localparam int unsigned EN_COINC  = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } lcd_mode_type;

   typedef struct packed {
      logic [3:0] machine_cycles;
      logic       lcd_on;
      logic [7:0] line_compare;
      logic [3:0] stat_enables;
   } req_item_type;

   typedef struct packed {
      logic [1:0] lcd_mode;
      logic [7:0] line_number;
      logic       coincidence;
      logic       vblank_request;
      logic       stat_request;
      logic       draw_request;
      logic [7:0] draw_line;
   } rsp_item_type;

endpackage

FILE: hdl/lst_step.sv
// ----------------------------------------------------------------------------
// lst_step
// timing state registers and the per-request update of counter, line and mode
// ----------------------------------------------------------------------------
module lst_step
   import lst_pkg::*;
#(
   parameter int unsigned DOTS_PER_LINE = 456,
   parameter int unsigned VISIBLE_LINES = 144,
   parameter int unsigned LAST_LINE     = 153
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam logic [8:0] DOTS_RELOAD = 9'(DOTS_PER_LINE);
   localparam logic [8:0] OAM_START   = 9'(DOTS_PER_LINE - OAM_DOTS);
   localparam logic [8:0] XFER_START  = 9'(DOTS_PER_LINE - OAM_DOTS - XFER_DOTS);
   localparam logic [8:0] VIS_LINE    = 9'(VISIBLE_LINES);
   localparam logic [8:0] LAST_LINE9  = 9'(LAST_LINE);

   logic [8:0]   dot_ff, dot_in;
   logic [7:0]   line_ff, line_in;
   lcd_mode_type mode_ff, mode_in;
   logic         coinc_ff, coinc_in;

   lcd_mode_type mode;
   logic         req_en;
   logic         coinc;
   logic [5:0]   dots_used;
   logic [9:0]   rest;
   logic         line_done;
   logic [8:0]   next_line;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff   <= DOTS_RELOAD;
         line_ff  <= '0;
         mode_ff  <= MODE_HBLANK;
         coinc_ff <= 1'b0;
      end else if (step) begin
         dot_ff   <= dot_in;
         line_ff  <= line_in;
         mode_ff  <= mode_in;
         coinc_ff <= coinc_in;
      end
   end

   always_comb begin
      // mode from the position before this request's dots are counted
      if ({1'b0, line_ff} >= VIS_LINE) begin
         mode = MODE_VBLANK;
      end else if (dot_ff >= OAM_START) begin
         mode = MODE_OAM;
      end else if (dot_ff >= XFER_START) begin
         mode = MODE_XFER;
      end else begin
         mode = MODE_HBLANK;
      end

      unique case (mode)
         MODE_HBLANK: req_en = item.stat_enables[EN_HBLANK];
         MODE_VBLANK: req_en = item.stat_enables[EN_VBLANK];
         MODE_OAM:    req_en = item.stat_enables[EN_OAM];
         MODE_XFER:   req_en = 1'b0;
         default:     req_en = 1'b0;
      endcase

      coinc     = (line_ff == item.line_compare);
      dots_used = {item.machine_cycles, 2'b00};
      rest      = {1'b0, dot_ff} - {4'b0000, dots_used};
      line_done = rest[9] || (rest == '0);
      next_line = {1'b0, line_ff} + 9'd1;

      dot_in   = dot_ff;
      line_in  = line_ff;
      mode_in  = mode;
      coinc_in = coinc;

      result.lcd_mode       = mode;
      result.line_number    = line_ff;
      result.coincidence    = coinc;
      result.vblank_request = 1'b0;
      result.stat_request   = (req_en && (mode != mode_ff))
                              || (coinc && item.stat_enables[EN_COINC]);
      result.draw_request   = 1'b0;
      result.draw_line      = '0;

      if (!item.lcd_on) begin
         // display off: park at the top of the frame in vblank
         dot_in   = DOTS_RELOAD;
         line_in  = '0;
         mode_in  = MODE_VBLANK;
         coinc_in = coinc_ff;
         result.lcd_mode     = MODE_VBLANK;
         result.line_number  = '0;
         result.coincidence  = coinc_ff;
         result.stat_request = 1'b0;
      end else if (line_done) begin
         // carry the overshoot into the new line
         dot_in = DOTS_RELOAD + rest[8:0];
         priority if (next_line == VIS_LINE) begin
            result.vblank_request = 1'b1;
            line_in = next_line[7:0];
         end else if (next_line > LAST_LINE9) begin
            result.draw_request = 1'b1;
            line_in = '0;
         end else if (next_line < VIS_LINE) begin
            result.draw_request = 1'b1;
            result.draw_line    = next_line[7:0];
            line_in = next_line[7:0];
         end else begin
            line_in = next_line[7:0];
         end
         result.line_number = line_in;
      end else begin
         dot_in = rest[8:0];
      end
   end

endmodule

FILE: hdl/lst_rsp_reg.sv
// ----------------------------------------------------------------------------
// lst_rsp_reg
// result register holding one response until the consumer takes it
// ----------------------------------------------------------------------------
module lst_rsp_reg
   import lst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load_valid,
   input  rsp_item_type load_item,
   output logic         load_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign load_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      item_in  = item_ff;
      if (load_valid && load_ready) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

FILE: hdl/lcd_scanline_timing_stat.sv
// ----------------------------------------------------------------------------
// lcd_scanline_timing_stat
// lcd line timing: dot counter, scan line, mode, stat/vblank/draw requests
// ----------------------------------------------------------------------------
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_item (cycles, lcd on, compare,
//                                           stat enables)
//   rsp      out        rsp_valid/rsp_stall  rsp_item (mode, line, flags, draw)
//
// one request per clock while rsp is not stalled; an accepted request goes through
// the input register, then the step logic into the result register, and shows
// on rsp from the result register
// the timing state updates in the same cycle the request leaves the input
// register, so consecutive requests see each other's state without bubbles
// reset clears the valid bits and puts the counter at a full line on line 0
// a stall on rsp holds the result register and then backs up into req_stall
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_scanline_timing_stat
   import lst_pkg::*;
#(
   parameter int unsigned DOTS_PER_LINE = 456,
   parameter int unsigned VISIBLE_LINES = 144,
   parameter int unsigned LAST_LINE     = 153
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   // input register
   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;

   // hand-off between step logic and result register
   logic         out_ready;
   logic         advance;
   rsp_item_type step_result;

   // the held request moves on whenever the result register can take it
   assign advance   = in_valid_ff && out_ready;
   // input register is free when empty or emptying this cycle
   assign req_stall = in_valid_ff && !out_ready;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_item_in  = in_item_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   // timing state and per-request step, committed only when the request advances
   lst_step #(
      .DOTS_PER_LINE (DOTS_PER_LINE),
      .VISIBLE_LINES (VISIBLE_LINES),
      .LAST_LINE     (LAST_LINE)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (step_result)
   );

   // result register, decouples consumer stalls from the step logic
   lst_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load_item  (step_result),
      .load_ready (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   // a draw always names the line just entered
   `ASSERT_IMPLY(a_draw_line_match, clock, reset, rsp_valid && rsp_item.draw_request, rsp_item.draw_line == rsp_item.line_number)

   // vblank is requested from the last visible line, never from a vblank line
   `ASSERT_IMPLY(a_vblank_from_visible, clock, reset, rsp_valid && rsp_item.vblank_request, rsp_item.lcd_mode != MODE_VBLANK)

   // draw and vblank requests never coincide
   `ASSERT_NEVER(a_draw_vblank_excl, clock, reset, rsp_valid && rsp_item.draw_request && rsp_item.vblank_request)

   // a held result with a full input register must push back on the requester
   `ASSERT_IMPLY(a_backpressure, clock, reset, rsp_valid && rsp_stall && in_valid_ff, req_stall)

endmodule

FILE: tb/sv/lcd_scanline_timing_stat_test.sv
// ----------------------------------------------------------------------------
// lcd_scanline_timing_stat_test
// self-checking bench for the lcd line timing and status block: a local
// model of the dot counter, scan line and mode predicts each result, random
// idle bursts on both channels, directed corners, then random and whole-frame
// request streams
// ----------------------------------------------------------------------------
module lcd_scanline_timing_stat_test;
   import lst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // block configuration, kept at the usual panel timing
   localparam int LINE_DOTS   = 456;
   localparam int VIS_LINES   = 144;
   localparam int LAST_LINE   = 153;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // idle bursts on both channels are allowed while this is set
   bit idle_on = 1'b1;

   int mismatch_count = 0;
   int cycle_count = 0;

   // local copy of the timing state
   int           dots_left;
   logic [7:0]   scan_line;
   lcd_mode_type last_mode;
   logic         line_match;

   // status results predicted for accepted requests, oldest first
   rsp_item_type predicted_status[$];

   lcd_scanline_timing_stat #(
      .DOTS_PER_LINE(LINE_DOTS),
      .VISIBLE_LINES(VIS_LINES),
      .LAST_LINE(LAST_LINE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   function automatic void reset_timing();
      dots_left  = LINE_DOTS;
      scan_line  = '0;
      last_mode  = MODE_HBLANK;
      line_match = 1'b0;
   endfunction

   // advance the timing state by one accepted request and queue its status
   function automatic void advance_scanline(input req_item_type item);
      rsp_item_type status;
      lcd_mode_type mode;
      logic         mode_en;
      int           rest;
      int           next_line;
      status = '0;
      if (!item.lcd_on) begin
         // panel off: timing held at the top of the frame, flag kept
         dots_left = LINE_DOTS;
         scan_line = '0;
         last_mode = MODE_VBLANK;
         status.lcd_mode    = MODE_VBLANK;
         status.coincidence = line_match;
      end else begin
         // mode comes from the counter before this step's dots are taken off
         if (scan_line >= VIS_LINES)
            mode = MODE_VBLANK;
         else if (dots_left >= LINE_DOTS - OAM_DOTS)
            mode = MODE_OAM;
         else if (dots_left >= LINE_DOTS - OAM_DOTS - XFER_DOTS)
            mode = MODE_XFER;
         else
            mode = MODE_HBLANK;
         // transfer has no enable of its own
         case (mode)
            MODE_VBLANK: mode_en = item.stat_enables[EN_VBLANK];
            MODE_OAM:    mode_en = item.stat_enables[EN_OAM];
            MODE_HBLANK: mode_en = item.stat_enables[EN_HBLANK];
            default:     mode_en = 1'b0;
         endcase
         status.stat_request = mode_en && (mode != last_mode);
         last_mode = mode;
         // coincidence raises stat on every step while enabled, not only on entry
         line_match = (scan_line == item.line_compare);
         if (line_match && item.stat_enables[EN_COINC])
            status.stat_request = 1'b1;
         rest = dots_left - 4 * int'(item.machine_cycles);
         if (rest <= 0) begin
            // line done, leftover dots carry into the next line
            next_line = int'(scan_line) + 1;
            dots_left = LINE_DOTS + rest;
            if (next_line == VIS_LINES) begin
               status.vblank_request = 1'b1;
            end else if (next_line > LAST_LINE) begin
               next_line = 0;
               status.draw_request = 1'b1;
            end else if (next_line < VIS_LINES) begin
               status.draw_request = 1'b1;
               status.draw_line    = 8'(next_line);
            end
            scan_line = 8'(next_line);
         end else begin
            dots_left = rest;
         end
         status.lcd_mode    = mode;
         status.line_number = scan_line;
         status.coincidence = line_match;
      end
      predicted_status.push_back(status);
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // present one request at the falling edge and hold it until accepted
   task automatic send_request(input req_item_type item);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_scanline(item);
   endtask

   function automatic req_item_type make_request(input int cycles, input bit on,
                                                 input int compare, input int enables);
      req_item_type item;
      item.machine_cycles = 4'(cycles);
      item.lcd_on         = on;
      item.line_compare   = 8'(compare);
      item.stat_enables   = 4'(enables);
      return item;
   endfunction

   // long steps favor the largest cycle count so whole frames go by quickly
   function automatic req_item_type random_request(input bit allow_off, input bit long_steps);
      req_item_type item;
      item.machine_cycles = (long_steps && $urandom_range(0, 3) != 0) ?
                            4'd15 : 4'($urandom_range(0, 15));
      item.lcd_on         = allow_off ? ($urandom_range(0, 5) != 0) : 1'b1;
      // often aim the compare at the current line to hit coincidence
      item.line_compare   = ($urandom_range(0, 3) == 0) ?
                            scan_line : 8'($urandom_range(0, 255));
      item.stat_enables   = 4'($urandom_range(0, 15));
      return item;
   endfunction

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------

   // random stall bursts, sampled by the block at the rising edge
   always begin
      @(negedge clock);
      if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 11)) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic void check_field(input string name, input int expected_val,
                                       input int actual_val);
      if (expected_val != actual_val) begin
         $error("%s: expected %0d, got %0d", name, expected_val, actual_val);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_status.size() == 0) begin
            $error("status result with no request outstanding");
            mismatch_count++;
         end else begin
            want = predicted_status.pop_front();
            check_field("lcd_mode", want.lcd_mode, rsp_item.lcd_mode);
            check_field("line_number", want.line_number, rsp_item.line_number);
            check_field("coincidence", want.coincidence, rsp_item.coincidence);
            check_field("vblank_request", want.vblank_request, rsp_item.vblank_request);
            check_field("stat_request", want.stat_request, rsp_item.stat_request);
            check_field("draw_request", want.draw_request, rsp_item.draw_request);
            check_field("draw_line", want.draw_line, rsp_item.draw_line);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // corners of one visible line, panel off and back on
   task automatic test_directed_corners();
      // zero cycles on a fresh line, compare hits line 0, every enable set
      send_request(make_request(0, 1'b1, 0, 4'hF));
      send_request(make_request(0, 1'b1, 255, 4'h0));
      // panel off with everything else at its top value
      send_request(make_request(15, 1'b0, 255, 4'hF));
      send_request(make_request(0, 1'b0, 0, 4'h0));
      // back on: vblank to oam change, oam enable only
      send_request(make_request(15, 1'b1, 200, 1 << EN_OAM));
      // walk the rest of the line through transfer and hblank into line 1
      repeat (8) send_request(make_request(15, 1'b1, 200, 4'hF));
      // coincidence on line 1 with only its enable, then without it
      send_request(make_request(1, 1'b1, 1, 1 << EN_COINC));
      send_request(make_request(1, 1'b1, 1, 4'h0));
      // hblank enable alone over another full line
      repeat (8) send_request(make_request(15, 1'b1, 255, 1 << EN_HBLANK));
   endtask

   // fully random requests with frequent panel off
   task automatic test_random_noise();
      repeat (120) send_request(random_request(1'b1, 1'b0));
   endtask

   // from the top of a frame through vblank and the wrap back to line 0
   task automatic test_full_frame();
      int         steps;
      bit         wrapped;
      logic [7:0] prev_line;
      steps   = 0;
      wrapped = 1'b0;
      send_request(make_request($urandom_range(0, 15), 1'b0, $urandom_range(0, 255),
                                $urandom_range(0, 15)));
      while (!wrapped && steps < 3000) begin
         prev_line = scan_line;
         send_request(random_request(1'b0, 1'b1));
         wrapped = (prev_line == LAST_LINE) && (scan_line == 0);
         steps++;
      end
      // a few lines into the next frame
      repeat (30) send_request(random_request(1'b0, 1'b1));
   endtask

   // no idling at all for the last part
   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (80) send_request(random_request($urandom_range(0, 7) == 0, 1'b1));
   endtask

   initial begin
      reset_timing();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_noise();
      test_full_frame();
      test_back_to_back();

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then a few cycles to catch anything extra
      while (predicted_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
